### rtl/core/chunked_bounds_frustum_culler_core_defines.svh
// ----------------------------------------------------------------------------
// chunked bounds frustum culler: assertion macros
// shared assertion forms for the checker files of the culler core
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BOUNDS_FRUSTUM_CULLER_CORE_DEFINES_SVH
`define CHUNKED_BOUNDS_FRUSTUM_CULLER_CORE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define CBFC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must also hold while reset is applied
`define CBFC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/cbfc_pkg.sv
// ----------------------------------------------------------------------------
// cbfc_pkg
// types and fixed constants shared by the frustum culler core files
// ----------------------------------------------------------------------------
package cbfc_pkg;

    // input selector codes
    typedef enum logic [1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_PLANE = 2'd2,
        FUNC_CULL  = 2'd3
    } func_t;

    // configuration register indexes
    localparam logic [1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [1:0] CFG_CHUNK_SIZE = 2'd1;
    localparam logic [1:0] CFG_CHUNKING   = 2'd2;

    // result kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_CULL = 1'b1;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int SLOT_W      = 12;
    localparam int CHUNK_NUM_W = 6;
    localparam int PLANE_W     = 32;
    localparam int NUM_PLANES  = 6;
    localparam int PLANE_SEL_W = 3;
    localparam int POS_W       = 32;
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 24;
    localparam int WIDE_W      = 18;
    localparam int ACC_SHIFT   = 16;

    localparam logic [CFG_W-1:0] RST_CAPACITY   = 13'd4096;
    localparam logic [CFG_W-1:0] RST_CHUNK_SIZE = 13'd64;
    localparam logic [CFG_W-1:0] ZERO_CHUNK_SUB = 13'd64;

endpackage

### rtl/core/cbfc_ram.sv
// ----------------------------------------------------------------------------
// cbfc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cbfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/cbfc_mac.sv
// ----------------------------------------------------------------------------
// cbfc_mac
// shared multiply-accumulate unit for plane distances
// ----------------------------------------------------------------------------
module cbfc_mac #(
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         first,
    input  logic signed [31:0]           n,
    input  logic signed [COORD_BITS-1:0] v,
    input  logic signed [31:0]           d,
    output logic                         neg
);

    localparam int PW = COORD_BITS + 32;
    localparam int AW = PW + 3;

    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] sum;

    // product register, then accumulate; the offset term seeds the sum
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(n) * PW'(v);
        if (first)
        begin
            acc_reg <= AW'(d) <<< cbfc_pkg::ACC_SHIFT;
        end
        else
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    // final distance sign
    assign sum = acc_reg + AW'(prod_reg);
    assign neg = sum[AW-1];

endmodule

### rtl/core/chunked_bounds_frustum_culler_core.sv
// ----------------------------------------------------------------------------
// chunked_bounds_frustum_culler_core
// chunked instance bounds with six-plane positive-vertex frustum culling
// ----------------------------------------------------------------------------
// Begin frame and load plane beats are taken in the idle state. An add does one
// read of the chunk's box row from the bounds ram, then the min/max write and
// the acknowledgment. A cull is accepted, then tests the chunk slots in turn; a
// non-empty chunk runs each plane it tests through the one shared
// multiply-accumulate unit and passes through a push state when it is listed;
// the end state closes the run. Add write, push and end wait while the output
// side stalls. Begin frame clears the per-chunk valid bits at once, so no
// clearing pass is needed. The input side is ready only between items.
// ----------------------------------------------------------------------------
module chunked_bounds_frustum_culler_core #(
    parameter int MAX_CHUNKS = 64,
    parameter int MAX_ITEMS  = 4096,
    parameter int COORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // config write port
    input  logic                                  cfg_we,
    input  logic [cbfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cbfc_pkg::CFG_W-1:0]            cfg_data,
    // input beats
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pos_x, pos_y, pos_z, plane_slot, plane_a, plane_b, plane_c, plane_d
    input  logic [cbfc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // func
    input  logic [1:0]                            s_axis_tuser,
    // result beats
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // instance_slot, buffer_full, chunk_number, none_visible
    output logic [cbfc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // kind
    output logic                                  m_axis_tuser,
    // last
    output logic                                  m_axis_tlast
);

    localparam int CIW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CCW  = $clog2(MAX_CHUNKS + 1);
    localparam int TW   = $clog2(MAX_ITEMS + 1);
    localparam int CB   = COORD_BITS;
    localparam int ROWW = 6 * CB;
    localparam int WW   = cbfc_pkg::WIDE_W;
    localparam int CW   = cbfc_pkg::CFG_W;

    localparam logic [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_CULL_RD,
        ST_CULL_MAC,
        ST_CULL_PUSH,
        ST_CULL_END
    } state_t;

    state_t state_reg;

    // config registers
    logic [CW-1:0] capacity_reg;
    logic [CW-1:0] chunk_size_reg;
    logic          chunking_reg;

    // frame counters
    logic [TW-1:0]  total_reg;
    logic [CCW-1:0] fill_chunk_reg;
    logic [CW-1:0]  fill_off_reg;
    logic [MAX_CHUNKS-1:0] valid_reg;

    // add work registers
    logic                 add_full_reg;
    logic                 add_upd_reg;
    logic [TW-1:0]        add_slot_reg;
    logic [CIW-1:0]       add_row_reg;
    logic signed [CB-1:0] pos_reg [3];

    // cull work registers
    logic [CCW-1:0] cnt_reg;
    logic [WW-1:0]  base_reg;
    logic [2:0]     p_reg;
    logic [1:0]     s_reg;
    logic           pend_valid_reg;
    logic [CCW-1:0] pend_chunk_reg;

    // plane store
    logic signed [31:0] plane_reg [cbfc_pkg::NUM_PLANES][4];

    // output register
    logic                           out_valid_reg;
    logic                           out_kind_reg;
    logic                           out_last_reg;
    logic [cbfc_pkg::SLOT_W-1:0]    out_slot_reg;
    logic                           out_full_reg;
    logic [cbfc_pkg::CHUNK_NUM_W-1:0] out_chunk_reg;
    logic                           out_none_reg;

    // input field views
    cbfc_pkg::func_t in_func;
    logic            accept;
    logic [2:0]      in_slot;

    assign in_func = cbfc_pkg::func_t'(s_axis_tuser);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign in_slot = s_axis_tdata[98:96];

    // effective sizes
    logic [CW-1:0] cs_eff;
    logic [WW-1:0] cap_eff;
    logic          out_free;
    logic          out_load;
    logic          is_full;
    logic [CW:0]   off_inc;

    assign cs_eff   = (chunk_size_reg == '0) ? cbfc_pkg::ZERO_CHUNK_SUB : chunk_size_reg;
    assign cap_eff  = (WW'(capacity_reg) > WW'(MAX_ITEMS)) ? WW'(MAX_ITEMS)
                                                            : WW'(capacity_reg);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign is_full  = WW'(total_reg) >= cap_eff;
    assign off_inc  = (CW+1)'(fill_off_reg) + (CW+1)'(1);

    // a new result beat enters the output register this cycle
    assign out_load = out_free && ((state_reg == ST_ADD_WR) ||
                                   (state_reg == ST_CULL_PUSH && pend_valid_reg) ||
                                   (state_reg == ST_CULL_END));

    // bounds ram control
    logic            ram_we;
    logic            ram_re;
    logic [CIW-1:0]  ram_raddr;
    logic [ROWW-1:0] ram_wdata;
    logic [ROWW-1:0] ram_rdata;
    logic [CIW-1:0]  cnt_idx;
    logic            cull_done;

    assign cnt_idx   = cnt_reg[CIW-1:0];
    assign cull_done = !chunking_reg || (cnt_reg == CCW'(MAX_CHUNKS)) || (base_reg >= cap_eff);

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = cnt_idx;
        if (state_reg == ST_IDLE && accept && in_func == cbfc_pkg::FUNC_ADD)
        begin
            ram_re    = 1'b1;
            ram_raddr = fill_chunk_reg[CIW-1:0];
        end
        else if (state_reg == ST_CULL_RD && !cull_done && valid_reg[cnt_idx])
        begin
            ram_re = 1'b1;
        end
    end

    assign ram_we = (state_reg == ST_ADD_WR) && out_free && add_upd_reg;

    // box row merge: empty rows read as the reset box
    always_comb
    begin
        logic signed [CB-1:0] lo;
        logic signed [CB-1:0] hi;
        for (int k = 0; k < 3; k++)
        begin
            lo = valid_reg[add_row_reg] ? ram_rdata[k*CB +: CB] : COORD_MAX;
            hi = valid_reg[add_row_reg] ? ram_rdata[(3+k)*CB +: CB] : COORD_MIN;
            ram_wdata[k*CB +: CB]     = (pos_reg[k] < lo) ? pos_reg[k] : lo;
            ram_wdata[(3+k)*CB +: CB] = (pos_reg[k] > hi) ? pos_reg[k] : hi;
        end
    end

    cbfc_ram #(
        .WIDTH (ROWW),
        .DEPTH (MAX_CHUNKS)
    ) u_bounds (
        .clk   (clk),
        .we    (ram_we),
        .waddr (add_row_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // positive-vertex operand select
    logic signed [31:0]    mac_n;
    logic signed [CB-1:0]  mac_v;
    logic                  mac_neg;

    assign mac_n = plane_reg[p_reg][s_reg];

    always_comb
    begin
        case (s_reg)
            2'd1:    mac_v = mac_n[31] ? ram_rdata[1*CB +: CB] : ram_rdata[4*CB +: CB];
            2'd2:    mac_v = mac_n[31] ? ram_rdata[2*CB +: CB] : ram_rdata[5*CB +: CB];
            default: mac_v = mac_n[31] ? ram_rdata[0*CB +: CB] : ram_rdata[3*CB +: CB];
        endcase
    end

    cbfc_mac #(
        .COORD_BITS (CB)
    ) u_mac (
        .clk   (clk),
        .first (s_reg == 2'd0),
        .n     (mac_n),
        .v     (mac_v),
        .d     (plane_reg[p_reg][3]),
        .neg   (mac_neg)
    );

    // plane store writes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && in_func == cbfc_pkg::FUNC_PLANE &&
            in_slot < 3'(cbfc_pkg::NUM_PLANES))
        begin
            plane_reg[in_slot][0] <= s_axis_tdata[130:99];
            plane_reg[in_slot][1] <= s_axis_tdata[162:131];
            plane_reg[in_slot][2] <= s_axis_tdata[194:163];
            plane_reg[in_slot][3] <= s_axis_tdata[226:195];
        end
    end

    // add payload capture
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && in_func == cbfc_pkg::FUNC_ADD)
        begin
            pos_reg[0]   <= s_axis_tdata[CB-1:0];
            pos_reg[1]   <= s_axis_tdata[32 +: CB];
            pos_reg[2]   <= s_axis_tdata[64 +: CB];
            add_slot_reg <= total_reg;
            add_row_reg  <= fill_chunk_reg[CIW-1:0];
        end
    end

    // sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= cbfc_pkg::RST_CAPACITY;
            chunk_size_reg <= cbfc_pkg::RST_CHUNK_SIZE;
            chunking_reg   <= 1'b1;
            total_reg      <= '0;
            fill_chunk_reg <= '0;
            fill_off_reg   <= '0;
            valid_reg      <= '0;
            add_full_reg   <= 1'b0;
            add_upd_reg    <= 1'b0;
            cnt_reg        <= '0;
            base_reg       <= '0;
            p_reg          <= '0;
            s_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_chunk_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
            out_slot_reg   <= '0;
            out_full_reg   <= 1'b0;
            out_chunk_reg  <= '0;
            out_none_reg   <= 1'b0;
        end
        else
        begin
            // config writes
            if (cfg_we)
            begin
                case (cfg_index)
                    cbfc_pkg::CFG_CAPACITY:   capacity_reg   <= cfg_data;
                    cbfc_pkg::CFG_CHUNK_SIZE: chunk_size_reg <= cfg_data;
                    cbfc_pkg::CFG_CHUNKING:   chunking_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            // result beat taken with nothing new behind it
            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_func)
                            cbfc_pkg::FUNC_BEGIN:
                            begin
                                total_reg      <= '0;
                                fill_chunk_reg <= '0;
                                fill_off_reg   <= '0;
                                valid_reg      <= '0;
                            end
                            cbfc_pkg::FUNC_ADD:
                            begin
                                add_full_reg <= is_full;
                                add_upd_reg  <= !is_full && chunking_reg &&
                                                (fill_chunk_reg < CCW'(MAX_CHUNKS));
                                if (!is_full)
                                begin
                                    total_reg <= total_reg + TW'(1);
                                    if (off_inc >= (CW+1)'(cs_eff))
                                    begin
                                        fill_off_reg <= '0;
                                        if (fill_chunk_reg < CCW'(MAX_CHUNKS))
                                        begin
                                            fill_chunk_reg <= fill_chunk_reg + CCW'(1);
                                        end
                                    end
                                    else
                                    begin
                                        fill_off_reg <= off_inc[CW-1:0];
                                    end
                                end
                                state_reg <= ST_ADD_WR;
                            end
                            cbfc_pkg::FUNC_CULL:
                            begin
                                cnt_reg        <= '0;
                                base_reg       <= '0;
                                pend_valid_reg <= 1'b0;
                                state_reg      <= ST_CULL_RD;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_ADD_WR:
                begin
                    if (out_free)
                    begin
                        if (add_upd_reg)
                        begin
                            valid_reg[add_row_reg] <= 1'b1;
                        end
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= cbfc_pkg::KIND_ADD;
                        out_last_reg  <= 1'b0;
                        out_full_reg  <= add_full_reg;
                        out_slot_reg  <= add_full_reg ? '0 : cbfc_pkg::SLOT_W'(add_slot_reg);
                        out_chunk_reg <= '0;
                        out_none_reg  <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                ST_CULL_RD:
                begin
                    if (cull_done)
                    begin
                        state_reg <= ST_CULL_END;
                    end
                    else if (!valid_reg[cnt_idx])
                    begin
                        cnt_reg  <= cnt_reg + CCW'(1);
                        base_reg <= base_reg + WW'(cs_eff);
                    end
                    else
                    begin
                        p_reg     <= '0;
                        s_reg     <= '0;
                        state_reg <= ST_CULL_MAC;
                    end
                end

                ST_CULL_MAC:
                begin
                    if (s_reg == 2'd3)
                    begin
                        s_reg <= '0;
                        if (mac_neg)
                        begin
                            cnt_reg   <= cnt_reg + CCW'(1);
                            base_reg  <= base_reg + WW'(cs_eff);
                            state_reg <= ST_CULL_RD;
                        end
                        else if (p_reg == 3'(cbfc_pkg::NUM_PLANES - 1))
                        begin
                            state_reg <= ST_CULL_PUSH;
                        end
                        else
                        begin
                            p_reg <= p_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        s_reg <= s_reg + 2'd1;
                    end
                end

                // hold one visible chunk back so the final one can carry last
                ST_CULL_PUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_kind_reg  <= cbfc_pkg::KIND_CULL;
                            out_last_reg  <= 1'b0;
                            out_full_reg  <= 1'b0;
                            out_slot_reg  <= '0;
                            out_chunk_reg <= cbfc_pkg::CHUNK_NUM_W'(pend_chunk_reg);
                            out_none_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_chunk_reg <= cnt_reg;
                        cnt_reg        <= cnt_reg + CCW'(1);
                        base_reg       <= base_reg + WW'(cs_eff);
                        state_reg      <= ST_CULL_RD;
                    end
                end

                ST_CULL_END:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= cbfc_pkg::KIND_CULL;
                        out_last_reg  <= 1'b1;
                        out_full_reg  <= 1'b0;
                        out_slot_reg  <= '0;
                        out_chunk_reg <= pend_valid_reg ?
                                         cbfc_pkg::CHUNK_NUM_W'(pend_chunk_reg) : '0;
                        out_none_reg  <= !pend_valid_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ports
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'b0, out_none_reg, out_chunk_reg, out_full_reg, out_slot_reg};

endmodule

### rtl/core/cbfc_checker.sv
// ----------------------------------------------------------------------------
// cbfc_checker
// port-level checks of the frustum culler core, bound to the top level
// ----------------------------------------------------------------------------
`include "chunked_bounds_frustum_culler_core_defines.svh"

module cbfc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_we,
    input logic [cbfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [cbfc_pkg::CFG_W-1:0]        cfg_data,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [cbfc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [1:0]                        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [cbfc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast
);

    // stalled result beat holds
    `CBFC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

    // add acknowledgments never close a run
    `CBFC_ASSERT(a_add_not_last, m_axis_tvalid && m_axis_tuser == cbfc_pkg::KIND_ADD |-> !m_axis_tlast && !m_axis_tdata[19], "add beat carries cull marks")

    // empty marker is the single closing cull beat
    `CBFC_ASSERT(a_none_form, m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tlast && m_axis_tuser == cbfc_pkg::KIND_CULL && m_axis_tdata[18:13] == 6'd0, "bad empty marker")

    // an add holds off the next input beat for its ram update
    `CBFC_ASSERT(a_add_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == cbfc_pkg::FUNC_ADD |=> !s_axis_tready, "input taken during add update")

    // nothing is offered right out of reset
    `CBFC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_axis_tvalid, "result beat right after reset")

endmodule

bind chunked_bounds_frustum_culler_core cbfc_checker u_cbfc_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for chunked_bounds_frustum_culler_core
// streams frame, add, plane and cull beats under random stalls through several
// register settings and checks every result beat against an in-bench predictor
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic       kind;
        logic [11:0] slot;
        logic       full;
        logic [5:0] chunk;
        logic       none;
        logic       last;
    } culler_result_t;

    // predicted culler state and queue of expected result beats
    class culler_scoreboard;
        int unsigned capacity = 4096;
        int unsigned chunk_len = 64;
        bit          chunking = 1;
        int unsigned total, fill_chunk, fill_offset;
        int unsigned members[64];
        logic signed [31:0] box_lo[192];
        logic signed [31:0] box_hi[192];
        logic signed [31:0] planes[24];
        culler_result_t expected_q[$];
        int mismatches;

        function new();
            clear_frame();
            foreach (planes[i]) planes[i] = '0;
        endfunction

        function void clear_frame();
            total = 0;
            fill_chunk = 0;
            fill_offset = 0;
            foreach (members[i]) members[i] = 0;
            foreach (box_lo[i])
            begin
                box_lo[i] = 32'sh7fffffff;
                box_hi[i] = 32'sh80000000;
            end
        endfunction

        // append one expected beat at the tail
        function void add_expected(culler_result_t r);
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void set_register(logic [1:0] idx, logic [12:0] val);
            if (idx == cbfc_pkg::CFG_CAPACITY) capacity = val;
            else if (idx == cbfc_pkg::CFG_CHUNK_SIZE) chunk_len = val;
            else if (idx == cbfc_pkg::CFG_CHUNKING) chunking = val[0];
        endfunction

        function bit chunk_visible(int c);
            logic signed [127:0] acc;
            longint n, v;
            for (int p = 0; p < 6; p++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                begin
                    n = planes[p*4+k];
                    v = (n >= 0) ? box_hi[c*3+k] : box_lo[c*3+k];
                    acc = acc + n * v;
                end
                acc = acc + longint'(planes[p*4+3]) * 65536;
                if (acc < 0) return 0;
            end
            return 1;
        endfunction

        function void note_item(cbfc_pkg::func_t f, logic [231:0] d);
            culler_result_t r;
            int unsigned cs, cap, nch, n;
            logic signed [31:0] pos[3];
            logic [2:0] ps;
            cs = (chunk_len == 0) ? 64 : chunk_len;
            cap = (capacity > 4096) ? 4096 : capacity;
            r = '0;
            case (f)
                cbfc_pkg::FUNC_BEGIN: clear_frame();
                cbfc_pkg::FUNC_ADD:
                begin
                    if (total >= cap)
                    begin
                        r.full = 1;
                        add_expected(r);
                    end
                    else
                    begin
                        r.slot = total[11:0];
                        total++;
                        if (chunking && fill_chunk < 64)
                        begin
                            pos[0] = d[31:0];
                            pos[1] = d[63:32];
                            pos[2] = d[95:64];
                            members[fill_chunk]++;
                            for (int k = 0; k < 3; k++)
                            begin
                                if (pos[k] < box_lo[fill_chunk*3+k]) box_lo[fill_chunk*3+k] = pos[k];
                                if (pos[k] > box_hi[fill_chunk*3+k]) box_hi[fill_chunk*3+k] = pos[k];
                            end
                        end
                        fill_offset++;
                        if (fill_offset >= cs)
                        begin
                            fill_offset = 0;
                            if (fill_chunk < 64) fill_chunk++;
                        end
                        add_expected(r);
                    end
                end
                cbfc_pkg::FUNC_PLANE:
                begin
                    ps = d[98:96];
                    if (ps < 6)
                        for (int k = 0; k < 4; k++) planes[ps*4+k] = d[99+32*k +: 32];
                end
                default:
                begin
                    n = 0;
                    r.kind = cbfc_pkg::KIND_CULL;
                    if (chunking)
                    begin
                        nch = (cap + cs - 1) / cs;
                        if (nch > 64) nch = 64;
                        for (int c = 0; c < nch; c++)
                            if (members[c] != 0 && chunk_visible(c))
                            begin
                                r.chunk = c[5:0];
                                add_expected(r);
                                n++;
                            end
                    end
                    if (n == 0)
                    begin
                        r.chunk = 0;
                        r.none = 1;
                        r.last = 1;
                        add_expected(r);
                    end
                    else
                        expected_q[$].last = 1;
                end
            endcase
        endfunction

        function void check_result(culler_result_t got);
            culler_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [cbfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cbfc_pkg::CFG_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [cbfc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [cbfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    culler_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    chunked_bounds_frustum_culler_core dut (.*);

    initial
    begin
        #100ms;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            m_axis_tready <= 0;
            repeat (400) @(negedge clk);
            hold_req = 0;
        end
        else
            m_axis_tready <= quiet || ($urandom_range(99) >= 7);
    end

    // result beat monitor
    always @(posedge clk)
    begin
        culler_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tuser;
            got.slot = m_axis_tdata[11:0];
            got.full = m_axis_tdata[12];
            got.chunk = m_axis_tdata[18:13];
            got.none = m_axis_tdata[19];
            got.last = m_axis_tlast;
            sb.check_result(got);
        end
    end

    task automatic send_beat(cbfc_pkg::func_t f, logic [231:0] d);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= f;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_item(f, d);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_register(idx, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [231:0] add_data(int mode);
        logic [231:0] d;
        d = 232'({$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom});
        if (mode == 0)
            for (int k = 0; k < 3; k++)
                d[32*k +: 32] = $signed($urandom_range(2097152)) - 32'sd1048576;
        return d;
    endfunction

    // plane beat: pass-all, random, or never-pass
    function automatic logic [231:0] plane_data(int slot, int mode);
        logic [231:0] d;
        d = '0;
        d[98:96] = 3'(slot);
        for (int k = 0; k < 3; k++)
            d[99+32*k +: 32] = (mode == 1) ? $urandom
                                           : $signed($urandom_range(512)) - 32'sd256;
        if (mode == 2)
        begin
            for (int k = 0; k < 3; k++) d[99+32*k +: 32] = '0;
            d[195 +: 32] = -$signed($urandom_range(1000, 1));
        end
        else
            d[195 +: 32] = (mode == 1) ? $urandom : 32'h7fffffff;
        return d;
    endfunction

    task automatic load_planes(int mode);
        for (int s = 0; s < 6; s++) send_beat(cbfc_pkg::FUNC_PLANE, plane_data(s, mode));
    endtask

    task automatic random_phase(int items);
        int r;
        send_beat(cbfc_pkg::FUNC_BEGIN, add_data(1));
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(99);
            if (r < 70) send_beat(cbfc_pkg::FUNC_ADD, add_data($urandom_range(1)));
            else if (r < 82) send_beat(cbfc_pkg::FUNC_PLANE,
                plane_data($urandom_range(7), ($urandom_range(9) < 6) ? 0 : $urandom_range(2, 1)));
            else if (r < 96) send_beat(cbfc_pkg::FUNC_CULL, add_data(1));
            else send_beat(cbfc_pkg::FUNC_BEGIN, add_data(1));
        end
        send_beat(cbfc_pkg::FUNC_CULL, add_data(1));
    endtask

    initial
    begin
        logic [231:0] d;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: extremes, every function, ignored slots, no-visible and full cases
        load_planes(0);
        d = '0;
        d[95:0] = {32'h7fffffff, 32'h80000000, 32'h7fffffff};
        send_beat(cbfc_pkg::FUNC_ADD, d);
        d[95:0] = {32'h80000000, 32'h7fffffff, 32'h80000000};
        send_beat(cbfc_pkg::FUNC_ADD, d);
        send_beat(cbfc_pkg::FUNC_CULL, d);
        send_beat(cbfc_pkg::FUNC_PLANE, plane_data(6, 2));
        send_beat(cbfc_pkg::FUNC_PLANE, plane_data(7, 2));
        send_beat(cbfc_pkg::FUNC_CULL, d);
        send_beat(cbfc_pkg::FUNC_PLANE, plane_data(3, 2));
        send_beat(cbfc_pkg::FUNC_CULL, d);
        send_beat(cbfc_pkg::FUNC_PLANE, plane_data(3, 1));
        send_beat(cbfc_pkg::FUNC_CULL, d);
        send_beat(cbfc_pkg::FUNC_BEGIN, d);
        send_beat(cbfc_pkg::FUNC_CULL, d);
        wait_idle();
        write_reg(cbfc_pkg::CFG_CAPACITY, 13'd0);
        write_reg(cbfc_pkg::CFG_CHUNK_SIZE, 13'd0);
        send_beat(cbfc_pkg::FUNC_ADD, d);
        send_beat(cbfc_pkg::FUNC_CULL, d);
        wait_idle();
        write_reg(cbfc_pkg::CFG_CAPACITY, 13'd1);
        write_reg(cbfc_pkg::CFG_CHUNKING, 13'd0);
        send_beat(cbfc_pkg::FUNC_ADD, d);
        send_beat(cbfc_pkg::FUNC_ADD, d);
        send_beat(cbfc_pkg::FUNC_CULL, d);
        wait_idle();

        // settings sweep with random content
        write_reg(cbfc_pkg::CFG_CAPACITY, 13'd8191);
        write_reg(cbfc_pkg::CFG_CHUNK_SIZE, 13'd1);
        write_reg(cbfc_pkg::CFG_CHUNKING, 13'd1);
        load_planes(0);
        quiet = 1;
        random_phase(90);
        quiet = 0;
        // long hold-off while the sender keeps going
        hold_req = 1;
        random_phase(40);
        wait_idle();
        write_reg(cbfc_pkg::CFG_CAPACITY, 13'd5);
        write_reg(cbfc_pkg::CFG_CHUNK_SIZE, 13'd2);
        random_phase(40);
        wait_idle();
        write_reg(cbfc_pkg::CFG_CAPACITY, 13'd4096);
        write_reg(cbfc_pkg::CFG_CHUNK_SIZE, 13'd8191);
        random_phase(50);
        wait_idle();
        write_reg(cbfc_pkg::CFG_CAPACITY, 13'd100);
        write_reg(cbfc_pkg::CFG_CHUNK_SIZE, 13'd7);
        write_reg(cbfc_pkg::CFG_CHUNKING, 13'd0);
        random_phase(40);
        wait_idle();
        write_reg(cbfc_pkg::CFG_CAPACITY, 13'd200);
        write_reg(cbfc_pkg::CFG_CHUNK_SIZE, 13'd3);
        write_reg(cbfc_pkg::CFG_CHUNKING, 13'd1);
        random_phase(80);
        wait_idle();
        write_reg(cbfc_pkg::CFG_CAPACITY, 13'd4096);
        write_reg(cbfc_pkg::CFG_CHUNK_SIZE, 13'd0);
        random_phase(80);

        wait_idle();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
